>>> hdl/hmm_sequence_sampler_unit_defines.svh
// Assertion macros for the HMM sequence sampler.
// Used by the top level; expects clk and rst in scope.
`ifndef HMM_SEQUENCE_SAMPLER_UNIT_DEFINES_SVH
`define HMM_SEQUENCE_SAMPLER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> hdl/hmmss_pkg.sv
// Shared types, codes and helpers of the HMM sequence sampler.
// No dependencies.
`default_nettype none
package hmmss_pkg;

  localparam int DEF_MAX_STATES         = 32;
  localparam int DEF_MAX_OBS_SYMBOLS    = 32;
  localparam int DEF_MAX_ACTION_SYMBOLS = 32;

  localparam int CNT_W  = 6;
  localparam int PROB_W = 16;
  localparam int SUM_W  = PROB_W + CNT_W;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;

  localparam logic [1:0] TABLE_INITIAL     = 2'd0;
  localparam logic [1:0] TABLE_TRANSITION  = 2'd1;
  localparam logic [1:0] TABLE_OBSERVATION = 2'd2;
  localparam logic [1:0] TABLE_ACTION      = 2'd3;

  localparam logic [1:0] CFG_STATES = 2'd0;
  localparam logic [1:0] CFG_OBS    = 2'd1;
  localparam logic [1:0] CFG_ACTION = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        table_select;
    logic [4:0]        row_index;
    logic [4:0]        column_index;
    logic [PROB_W-1:0] probability;
    logic [PROB_W-1:0] draw_state;
    logic [PROB_W-1:0] draw_observation;
    logic [PROB_W-1:0] draw_action;
  } request_t;

  typedef struct packed {
    logic [4:0] present_state;
    logic [4:0] observation;
    logic       observation_valid;
    logic [4:0] action;
    logic       action_valid;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } seq_state_t;

  typedef struct packed {
    logic             clear;
    logic             rd_valid;
    logic [CNT_W-1:0] idx;
  } walk_ctrl_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v, input int top);
    if (int'(v) > top) begin
      return CNT_W'(top);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hdl/hmmss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hmmss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/hmmss_walker.sv
// Inverse-CDF row walker: running sum, compare against draw, first hit.
// Depends on hmmss_pkg.
`default_nettype none
module hmmss_walker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire hmmss_pkg::walk_ctrl_t          ctrl,
  input  wire logic [hmmss_pkg::CNT_W-1:0]    count,
  input  wire logic [hmmss_pkg::PROB_W-1:0]   draw,
  input  wire logic [hmmss_pkg::PROB_W-1:0]   rdata,
  output logic      [hmmss_pkg::CNT_W-1:0]    result
);
  import hmmss_pkg::*;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic             found;
  logic             active;
  logic             hit;

  always_comb begin
    sum_next = sum + SUM_W'(rdata);
    active   = ctrl.rd_valid && !found && (ctrl.idx < count);
    hit      = active && ((SUM_W'(draw) <= sum_next) || (ctrl.idx == count - 1'b1));
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum    <= '0;
      found  <= 1'b0;
      result <= '0;
    end else begin
      if (active) begin
        sum <= sum_next;
      end
      if (hit) begin
        found  <= 1'b1;
        result <= ctrl.idx;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/hmm_sequence_sampler_unit.sv
// Top level of the HMM sequence sampler: command port, table RAMs, walk sequencer.
// Depends on hmmss_pkg, hmmss_ram, hmmss_walker and the assertion macro header.
//
// Use:
//   Configuration: cfg_valid/cfg_ready (ready always high) write cfg_data to
//   register cfg_index (0 states in use, 1 observation symbols, 2 action symbols).
//   Commands: a request word is taken on a clock edge with start high and busy low.
//   A load word writes one table entry in that same cycle and leaves busy low.
//   A start or step word raises busy while one index counter sweeps the rows;
//   three walker lanes (next state, observation, action) share that counter,
//   each reading its own RAM read port, each RAM giving one entry per cycle.
//   Busy stays high until the sweep covers N entries, N the largest count in use
//   for the word, and a new start or step word is taken only once busy is low.
//   A step word returns one result word on the result port, marked by done for
//   exactly one cycle, in the first cycle with busy low; the receiver cannot stall.
//   Start words and load words return nothing.
//   Reset clears the current state and configuration (1, 0, 0); table contents
//   are undefined until loaded and there is no clearing pass.
`default_nettype none
`include "hmm_sequence_sampler_unit_defines.svh"
module hmm_sequence_sampler_unit #(
  parameter int MAX_STATES         = hmmss_pkg::DEF_MAX_STATES,
  parameter int MAX_OBS_SYMBOLS    = hmmss_pkg::DEF_MAX_OBS_SYMBOLS,
  parameter int MAX_ACTION_SYMBOLS = hmmss_pkg::DEF_MAX_ACTION_SYMBOLS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire hmmss_pkg::request_t          request,
  output logic                              done,
  output hmmss_pkg::result_t                result,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [hmmss_pkg::CNT_W-1:0]  cfg_data
);
  import hmmss_pkg::*;

  localparam int AW_I = $clog2(MAX_STATES);
  localparam int AW_T = $clog2(MAX_STATES * MAX_STATES);
  localparam int AW_O = $clog2(MAX_STATES * MAX_OBS_SYMBOLS);
  localparam int AW_A = $clog2(MAX_STATES * MAX_ACTION_SYMBOLS);
  localparam int SW   = (MAX_STATES > 32) ? CNT_W : $clog2(MAX_STATES);

  seq_state_t state, state_next;

  logic [CNT_W-1:0]  cfg_states;
  logic [CNT_W-1:0]  cfg_obs;
  logic [CNT_W-1:0]  cfg_act;
  logic [SW-1:0]     cur_state;

  logic [CNT_W-1:0]  j;
  logic              rd_valid;
  logic [CNT_W-1:0]  idx_d;
  logic              is_start;
  logic              is_step;
  logic [CNT_W-1:0]  cnt_s, cnt_o, cnt_a, max_cnt;
  logic [PROB_W-1:0] draw_s, draw_o, draw_a;
  logic [AW_T-1:0]   base_t;
  logic [AW_O-1:0]   base_o;
  logic [AW_A-1:0]   base_a;

  logic              accept;
  logic              walk_cmd;
  logic              issue;
  logic              walk_end;
  logic              load_ok;
  logic [CNT_W-1:0]  n_hidden;
  logic [CNT_W-1:0]  n_obs;
  logic [CNT_W-1:0]  n_act;
  logic [CNT_W-1:0]  n_obs_cmd;
  logic [CNT_W-1:0]  n_act_cmd;
  logic [CNT_W-1:0]  n_max_cmd;

  logic              we_i, we_t, we_o, we_a;
  logic [PROB_W-1:0] rd_i, rd_t, rd_o, rd_a;
  logic [PROB_W-1:0] rd_s;
  walk_ctrl_t        wctrl;
  logic [CNT_W-1:0]  res_s, res_o, res_a;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign walk_cmd  = (request.kind == KIND_START) || (request.kind == KIND_STEP);
  assign issue     = (state == ST_WALK) && (j < max_cnt);
  assign walk_end  = (state == ST_WALK) && !issue && !rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_states <= CNT_W'(1);
      cfg_obs    <= '0;
      cfg_act    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STATES: cfg_states <= cfg_data;
        CFG_OBS:    cfg_obs    <= cfg_data;
        CFG_ACTION: cfg_act    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    n_hidden = clamp_count(cfg_states, MAX_STATES);
    if (n_hidden == '0) begin
      n_hidden = CNT_W'(1);
    end
    n_obs     = clamp_count(cfg_obs, MAX_OBS_SYMBOLS);
    n_act     = clamp_count(cfg_act, MAX_ACTION_SYMBOLS);
    n_obs_cmd = (request.kind == KIND_STEP) ? n_obs : '0;
    n_act_cmd = (request.kind == KIND_STEP) ? n_act : '0;
    n_max_cmd = n_hidden;
    if (n_obs_cmd > n_max_cmd) begin
      n_max_cmd = n_obs_cmd;
    end
    if (n_act_cmd > n_max_cmd) begin
      n_max_cmd = n_act_cmd;
    end
  end

  always_comb begin
    load_ok = accept && (request.kind == KIND_LOAD) && (int'(request.row_index) < MAX_STATES);
    we_i = load_ok && (request.table_select == TABLE_INITIAL);
    we_t = load_ok && (request.table_select == TABLE_TRANSITION)
           && (int'(request.column_index) < MAX_STATES);
    we_o = load_ok && (request.table_select == TABLE_OBSERVATION)
           && (int'(request.column_index) < MAX_OBS_SYMBOLS);
    we_a = load_ok && (request.table_select == TABLE_ACTION)
           && (int'(request.column_index) < MAX_ACTION_SYMBOLS);
  end

  hmmss_ram #(.WIDTH(PROB_W), .DEPTH(MAX_STATES)) u_ram_initial (
    .clk   (clk),
    .we    (we_i),
    .waddr (AW_I'(request.row_index)),
    .wdata (request.probability),
    .raddr (AW_I'(j)),
    .rdata (rd_i)
  );

  hmmss_ram #(.WIDTH(PROB_W), .DEPTH(MAX_STATES * MAX_STATES)) u_ram_transition (
    .clk   (clk),
    .we    (we_t),
    .waddr (AW_T'(request.row_index) * AW_T'(MAX_STATES) + AW_T'(request.column_index)),
    .wdata (request.probability),
    .raddr (base_t + AW_T'(j)),
    .rdata (rd_t)
  );

  hmmss_ram #(.WIDTH(PROB_W), .DEPTH(MAX_STATES * MAX_OBS_SYMBOLS)) u_ram_observation (
    .clk   (clk),
    .we    (we_o),
    .waddr (AW_O'(request.row_index) * AW_O'(MAX_OBS_SYMBOLS) + AW_O'(request.column_index)),
    .wdata (request.probability),
    .raddr (base_o + AW_O'(j)),
    .rdata (rd_o)
  );

  hmmss_ram #(.WIDTH(PROB_W), .DEPTH(MAX_STATES * MAX_ACTION_SYMBOLS)) u_ram_action (
    .clk   (clk),
    .we    (we_a),
    .waddr (AW_A'(request.row_index) * AW_A'(MAX_ACTION_SYMBOLS) + AW_A'(request.column_index)),
    .wdata (request.probability),
    .raddr (base_a + AW_A'(j)),
    .rdata (rd_a)
  );

  always_comb begin
    wctrl.clear    = accept && walk_cmd;
    wctrl.rd_valid = rd_valid;
    wctrl.idx      = idx_d;
    rd_s           = is_start ? rd_i : rd_t;
  end

  hmmss_walker u_walk_state (
    .clk(clk), .rst(rst), .ctrl(wctrl), .count(cnt_s), .draw(draw_s), .rdata(rd_s),
    .result(res_s)
  );

  hmmss_walker u_walk_obs (
    .clk(clk), .rst(rst), .ctrl(wctrl), .count(cnt_o), .draw(draw_o), .rdata(rd_o),
    .result(res_o)
  );

  hmmss_walker u_walk_action (
    .clk(clk), .rst(rst), .ctrl(wctrl), .count(cnt_a), .draw(draw_a), .rdata(rd_a),
    .result(res_a)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && walk_cmd) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j         <= '0;
      rd_valid  <= 1'b0;
      is_start  <= 1'b0;
      is_step   <= 1'b0;
      cur_state <= '0;
      done      <= 1'b0;
    end else begin
      done     <= 1'b0;
      rd_valid <= issue;
      if (issue) begin
        j <= j + 1'b1;
      end
      if (accept && walk_cmd) begin
        j        <= '0;
        is_start <= (request.kind == KIND_START);
        is_step  <= (request.kind == KIND_STEP);
      end
      if (walk_end) begin
        cur_state <= SW'(res_s);
        done      <= is_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_d <= j;
    if (accept && walk_cmd) begin
      cnt_s   <= n_hidden;
      cnt_o   <= n_obs_cmd;
      cnt_a   <= n_act_cmd;
      max_cnt <= n_max_cmd;
      draw_s  <= request.draw_state;
      draw_o  <= request.draw_observation;
      draw_a  <= request.draw_action;
      base_t  <= AW_T'(cur_state) * AW_T'(MAX_STATES);
      base_o  <= AW_O'(cur_state) * AW_O'(MAX_OBS_SYMBOLS);
      base_a  <= AW_A'(cur_state) * AW_A'(MAX_ACTION_SYMBOLS);
    end
    if (walk_end) begin
      result.present_state     <= 5'(cur_state);
      result.observation       <= 5'(res_o);
      result.observation_valid <= (cnt_o != '0);
      result.action            <= 5'(res_a);
      result.action_valid      <= (cnt_a != '0);
    end
  end

  `ASSERT_NEXT(a_walk_goes_busy, accept && walk_cmd, busy, "start or step word did not raise busy")
  `ASSERT_IMPLIES(a_done_when_idle, done, !busy, "result strobe while still walking")
  `ASSERT_IMPLIES(a_read_in_walk, rd_valid, state == ST_WALK, "RAM data valid outside a walk")
  `ASSERT_IMPLIES(a_obs_off_zero, done && !result.observation_valid, result.observation == '0,
                  "observation not zero while disabled")

endmodule
`default_nettype wire
